// File: hdl/bais_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array insert and search: shared definitions
// Operation codes, status codes and the structures passed between the top
// level and the sequencer.
// ----------------------------------------------------------------------------
package bais_pkg;

   typedef enum logic [2:0] {
      OP_CLEAR      = 3'd0,
      OP_INS_FRONT  = 3'd1,
      OP_INS_END    = 3'd2,
      OP_INS_SORTED = 3'd3,
      OP_INS_POS    = 3'd4,
      OP_LSEARCH    = 3'd5,
      OP_BSEARCH    = 3'd6,
      OP_READ       = 3'd7
   } op_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      op_type     opcode;
      logic [6:0] position;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  found_location;
      logic [31:0] key_out;
      logic [6:0]  count;
      logic        full_res;
   } result_type;

endpackage

// File: hdl/bounded_array_insert_search.sv
// After acceptance, clear, rejected words, end or positional inserts that land at the end of
// the array and any insert into an empty array go straight to the result; a read first waits
// for the RAM data; other inserts shift one entry at a time, linear search compares one entry
// at a time and binary search issues and then compares each probe. One word is in work at a
// time; with no output stall the next is taken the cycle after its result enters the output
// register. Reset clears the entry count; key memory stays undefined, with no clearing pass.
// ----------------------------------------------------------------------------
// Bounded array insert and search
// Keeps a bounded array of signed keys with front, end, sorted and
// positional insert, linear and binary search, and read by position.
// ----------------------------------------------------------------------------
module bounded_array_insert_search
   import bais_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_key_in,
   input  logic [6:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_found_location,
   output logic signed [31:0] rsp_key_out,
   output logic [6:0]         rsp_count,
   output logic               rsp_full_res
);

   localparam int XW = KEY_WIDTH + 32;

   cmd_type              cmd;
   logic signed [XW-1:0] key_wide;
   logic                 start;
   logic                 busy;
   logic                 res_valid;
   logic                 slot_free;
   result_type           res;
   result_type           rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign cmd.opcode   = op_type'(req_opcode);
   assign cmd.position = req_position;
   assign key_wide     = XW'(req_key_in);
   assign start        = req_valid && !busy;
   assign req_stall    = busy;
   assign slot_free    = !rsp_valid_ff || !rsp_stall;

   bais_ctrl #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .key       (key_wide[KEY_WIDTH-1:0]),
      .busy      (busy),
      .res_valid (res_valid),
      .res_ready (slot_free),
      .res       (res)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_valid && slot_free) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_found_location = rsp_ff.found_location;
   assign rsp_key_out        = rsp_ff.key_out;
   assign rsp_count          = rsp_ff.count;
   assign rsp_full_res       = rsp_ff.full_res;

endmodule

// File: hdl/bais_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bais_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bais_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded array insert and search: sequencer
// Holds the entry count and walks the key memory for shifting inserts,
// linear search, binary search and reads.
// ----------------------------------------------------------------------------
module bais_ctrl
   import bais_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cmd_type              cmd,
   input  logic [KEY_WIDTH-1:0] key,
   output logic                 busy,
   output logic                 res_valid,
   input  logic                 res_ready,
   output result_type           res
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > 7) ? CW : 7) + 1;
   localparam int XW = KEY_WIDTH + 32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SH_LOOP,
      S_SH_KEY,
      S_LS_CMP,
      S_BS_ISSUE,
      S_BS_CMP,
      S_RD_WAIT,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        stop_ff, stop_in;
   logic                 sorted_ff, sorted_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi1_ff, hi1_in;
   result_type           res_ff, res_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;

   logic [EW-1:0]        count_ext;
   logic [EW-1:0]        pos_ext;
   logic [EW-1:0]        hit_ext;
   logic signed [XW-1:0] rd_wide;
   logic [CW:0]          mid_sum;
   logic                 is_full;

   bais_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_ext = EW'(count_ff);
   assign pos_ext   = EW'(cmd.position);
   assign hit_ext   = EW'(idx_ff) + EW'(1);
   assign rd_wide   = XW'($signed(rd_data));
   assign mid_sum   = (CW+1)'(lo_ff) + (CW+1)'(hi1_ff) - (CW+1)'(1);
   assign is_full   = (count_ff == CW'(CAPACITY));

   always_comb begin
      logic [AW-1:0] stop_c;
      logic [AW-1:0] next_idx;
      logic          go_on;

      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      stop_in   = stop_ff;
      sorted_in = sorted_ff;
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi1_in    = hi1_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = key_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      stop_c    = '0;
      next_idx  = idx_ff - AW'(1);
      go_on     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_in    = '0;
               key_in    = key;
               sorted_in = (cmd.opcode == OP_INS_SORTED);
               unique case (cmd.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  OP_INS_FRONT, OP_INS_END, OP_INS_SORTED, OP_INS_POS: begin
                     unique case (cmd.opcode)
                        OP_INS_END: stop_c = count_ff[AW-1:0];
                        OP_INS_POS: stop_c = AW'(pos_ext - EW'(1));
                        default:    stop_c = '0;
                     endcase
                     stop_in = stop_c;
                     idx_in  = count_ff[AW-1:0];
                     if (is_full) begin
                        res_in.status = STATUS_FULL;
                        state_in      = S_DONE;
                     end else if (cmd.opcode == OP_INS_POS &&
                                  (pos_ext == '0 || pos_ext > count_ext + EW'(1))) begin
                        res_in.status = STATUS_RANGE;
                        state_in      = S_DONE;
                     end else if (count_ff[AW-1:0] == stop_c) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = key;
                        count_in = count_ff + CW'(1);
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = count_ff[AW-1:0] - AW'(1);
                        state_in = S_SH_LOOP;
                     end
                  end
                  OP_LSEARCH: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_LS_CMP;
                     end
                  end
                  OP_BSEARCH: begin
                     lo_in    = '0;
                     hi1_in   = count_ff;
                     state_in = S_BS_ISSUE;
                  end
                  OP_READ: begin
                     if (pos_ext == '0 || pos_ext > count_ext) begin
                        res_in.status = STATUS_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(pos_ext - EW'(1));
                        state_in = S_RD_WAIT;
                     end
                  end
               endcase
            end
         end
         S_SH_LOOP: begin
            go_on = !sorted_ff || ($signed(rd_data) > $signed(key_ff));
            if (go_on) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data;
               idx_in  = next_idx;
               if (next_idx == stop_ff) begin
                  state_in = S_SH_KEY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(2);
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end
         end
         S_SH_KEY: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_LS_CMP: begin
            if (rd_data == key_ff) begin
               res_in.found_location = hit_ext[6:0];
               state_in              = S_DONE;
            end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(1);
               idx_in  = idx_ff + AW'(1);
            end
         end
         S_BS_ISSUE: begin
            if (lo_ff < hi1_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_sum[AW:1];
               idx_in   = mid_sum[AW:1];
               state_in = S_BS_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BS_CMP: begin
            if (rd_data == key_ff) begin
               res_in.found_location = hit_ext[6:0];
               state_in              = S_DONE;
            end else begin
               if ($signed(rd_data) > $signed(key_ff)) begin
                  hi1_in = CW'(idx_ff);
               end else begin
                  lo_in = CW'(idx_ff) + CW'(1);
               end
               state_in = S_BS_ISSUE;
            end
         end
         S_RD_WAIT: begin
            res_in.key_out = rd_wide[31:0];
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      stop_ff   <= stop_in;
      sorted_ff <= sorted_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi1_ff    <= hi1_in;
      res_ff    <= res_in;
   end

   always_comb begin
      res                = res_ff;
      res.count          = count_ext[6:0];
      res.full_res       = is_full;
   end

   assign busy      = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("Shift reads the entry it writes in the same cycle.");

   a_shift_above_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_LOOP || state_ff == S_SH_KEY) |-> (idx_ff >= stop_ff))
      else $error("Shift pointer passed the insert position.");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !res_ready) |=> (state_ff == S_DONE && $stable(res_ff)))
      else $error("Result left before the output register took it.");

   a_count_only_on_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && !wr_en) |=> $stable(count_ff))
      else $error("Entry count changed without a key write.");

endmodule

// File: verif/tb_bounded_array_insert_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bounded array insert and search block
// A directed table and a long random run of words are driven through the
// request channel under changing idle patterns and one long output hold-off.
// Every result is compared field by field with a typed table row's expected value,
// else with a behavioral model of the key array kept in the testbench.
// ----------------------------------------------------------------------------
module tb_bounded_array_insert_search
   import bais_pkg::*;
();

   localparam int CAPACITY   = 64;
   localparam int DIR_ROWS   = 25;
   localparam int RAND_WORDS = 400;
   localparam int HOLD_OFF   = 400;
   localparam int END_DRAIN  = 200;
   localparam int LIMIT      = 400000;

   typedef struct {
      op_type             op;
      logic signed [31:0] key;
      logic [6:0]         pos;
      bit                 typed;
      result_type         exp;
   } word_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_opcode = '0;
   logic signed [31:0] req_key_in = '0;
   logic [6:0]         req_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_found_location;
   logic signed [31:0] rsp_key_out;
   logic [6:0]         rsp_count;
   logic               rsp_full_res;

   word_row_type       dir_rows [DIR_ROWS];
   word_row_type       words [$];
   result_type         resp_expected [$];
   logic signed [31:0] key_store [CAPACITY];
   int                 key_count = 0;
   int                 gen_count = 0;
   logic signed [31:0] gen_keys [$];
   int                 next_word = 0;
   int                 words_taken = 0;
   int                 load_phase = 0;
   int                 hold_left = 0;
   bit                 pressure_done = 1'b0;
   int                 mismatch_n = 0;
   int                 cycle_n = 0;

   bounded_array_insert_search u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_key_in         (req_key_in),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_location (rsp_found_location),
      .rsp_key_out        (rsp_key_out),
      .rsp_count          (rsp_count),
      .rsp_full_res       (rsp_full_res)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Behavior of one word on the key array; updates the array and the count.
   function automatic result_type apply_word(op_type op, logic signed [31:0] key,
                                             logic [6:0] pos);
      result_type r;
      int         lo;
      int         hi;
      int         mid;
      int         i;
      r = '0;
      if (op != OP_CLEAR && op <= OP_INS_POS && key_count >= CAPACITY) begin
         r.status = STATUS_FULL;
      end else begin
         case (op)
            OP_CLEAR: begin
               key_count = 0;
            end
            OP_INS_FRONT: begin
               for (i = key_count; i > 0; i--) key_store[i] = key_store[i - 1];
               key_store[0] = key;
               key_count++;
            end
            OP_INS_END: begin
               key_store[key_count] = key;
               key_count++;
            end
            OP_INS_SORTED: begin
               i = key_count;
               while (i > 0 && key_store[i - 1] > key) begin
                  key_store[i] = key_store[i - 1];
                  i--;
               end
               key_store[i] = key;
               key_count++;
            end
            OP_INS_POS: begin
               if (pos == 0 || pos > key_count + 1) begin
                  r.status = STATUS_RANGE;
               end else begin
                  for (i = key_count; i > pos - 1; i--) key_store[i] = key_store[i - 1];
                  key_store[pos - 1] = key;
                  key_count++;
               end
            end
            OP_LSEARCH: begin
               for (i = 0; i < key_count; i++) begin
                  if (key_store[i] == key) begin
                     r.found_location = 7'(i + 1);
                     break;
                  end
               end
            end
            OP_BSEARCH: begin
               lo = 0;
               hi = key_count - 1;
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  if (key_store[mid] == key) begin
                     r.found_location = 7'(mid + 1);
                     break;
                  end
                  if (key_store[mid] > key) hi = mid - 1;
                  else lo = mid + 1;
               end
            end
            default: begin
               if (pos == 0 || pos > key_count) r.status = STATUS_RANGE;
               else r.key_out = key_store[pos - 1];
            end
         endcase
      end
      r.count = 7'(key_count);
      r.full_res = (key_count == CAPACITY);
      return r;
   endfunction

   // Appends a word and tracks the array fill so that later words can aim
   // at valid positions and at keys already stored.
   function automatic void queue_word(op_type op, logic signed [31:0] key, logic [6:0] pos,
                                      bit typed, result_type exp);
      word_row_type w;
      w.op = op;
      w.key = key;
      w.pos = pos;
      w.typed = typed;
      w.exp = exp;
      words.push_back(w);
      case (op)
         OP_CLEAR: begin
            gen_count = 0;
            gen_keys.delete();
         end
         OP_INS_FRONT, OP_INS_END, OP_INS_SORTED: begin
            if (gen_count < CAPACITY) begin
               gen_count++;
               gen_keys.push_back(key);
            end
         end
         OP_INS_POS: begin
            if (gen_count < CAPACITY && pos != 0 && pos <= gen_count + 1) begin
               gen_count++;
               gen_keys.push_back(key);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_key(bit from_array);
      int sel;
      sel = $urandom_range(0, 9);
      if (from_array && gen_keys.size() > 0 && sel < 6)
         return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
      if (sel < 3) return $urandom_range(0, 20) - 10;
      if (sel < 5) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [6:0] pick_pos(int hi_valid);
      if (hi_valid >= 1 && $urandom_range(0, 4) != 0) return 7'($urandom_range(1, hi_valid));
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic void build_stimulus();
      int     fill_n;
      int     query_n;
      int     k;
      bit     sorted_mode;
      bit     first;
      op_type op;
      dir_rows = '{
         '{OP_READ,       32'sd0,          7'd1,   1'b1, '{STATUS_RANGE, 7'd0, 32'd0, 7'd0, 1'b0}},
         '{OP_BSEARCH,    32'sd5,          7'd0,   1'b1, '{STATUS_OK,    7'd0, 32'd0, 7'd0, 1'b0}},
         '{OP_LSEARCH,    -32'sd5,         7'd0,   1'b1, '{STATUS_OK,    7'd0, 32'd0, 7'd0, 1'b0}},
         '{OP_INS_POS,    32'sd1,          7'd0,   1'b1, '{STATUS_RANGE, 7'd0, 32'd0, 7'd0, 1'b0}},
         '{OP_INS_POS,    32'sd1,          7'd2,   1'b1, '{STATUS_RANGE, 7'd0, 32'd0, 7'd0, 1'b0}},
         '{OP_INS_END,    32'sh7fff_ffff,  7'd127, 1'b1, '{STATUS_OK,    7'd0, 32'd0, 7'd1, 1'b0}},
         '{OP_INS_FRONT,  32'sh8000_0000,  7'd0,   1'b1, '{STATUS_OK,    7'd0, 32'd0, 7'd2, 1'b0}},
         '{OP_INS_SORTED, 32'sd0,          7'd64,  1'b0, '0},
         '{OP_INS_POS,    -32'sd1,         7'd2,   1'b0, '0},
         '{OP_INS_POS,    32'sd42,         7'd5,   1'b0, '0},
         '{OP_READ,       32'sd0,          7'd1,   1'b0, '0},
         '{OP_READ,       32'sd0,          7'd5,   1'b0, '0},
         '{OP_READ,       32'sd0,          7'd6,   1'b1, '{STATUS_RANGE, 7'd0, 32'd0, 7'd5, 1'b0}},
         '{OP_READ,       32'sd0,          7'd127, 1'b1, '{STATUS_RANGE, 7'd0, 32'd0, 7'd5, 1'b0}},
         '{OP_LSEARCH,    32'sh7fff_ffff,  7'd0,   1'b0, '0},
         '{OP_BSEARCH,    32'sd42,         7'd0,   1'b0, '0},
         '{OP_CLEAR,      32'sd0,          7'd0,   1'b1, '{STATUS_OK,    7'd0, 32'd0, 7'd0, 1'b0}},
         '{OP_INS_SORTED, 32'sd5,          7'd0,   1'b0, '0},
         '{OP_INS_SORTED, 32'sd3,          7'd0,   1'b0, '0},
         '{OP_INS_SORTED, 32'sd5,          7'd0,   1'b0, '0},
         '{OP_INS_SORTED, -32'sd7,         7'd0,   1'b0, '0},
         '{OP_BSEARCH,    32'sd5,          7'd0,   1'b0, '0},
         '{OP_LSEARCH,    32'sd5,          7'd0,   1'b0, '0},
         '{OP_LSEARCH,    32'sd99,         7'd0,   1'b0, '0},
         '{OP_READ,       32'sd0,          7'd0,   1'b1, '{STATUS_RANGE, 7'd0, 32'd0, 7'd4, 1'b0}}
      };
      foreach (dir_rows[i])
         queue_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].pos, dir_rows[i].typed,
                    dir_rows[i].exp);

      first = 1'b1;
      while (words.size() < DIR_ROWS + RAND_WORDS) begin
         if (first || $urandom_range(0, 4) != 0)
            queue_word(OP_CLEAR, $urandom, 7'($urandom_range(0, 127)), 1'b0, '0);
         if (first || $urandom_range(0, 6) == 0) fill_n = CAPACITY + 2;
         else fill_n = $urandom_range(0, 16);
         sorted_mode = $urandom_range(0, 1);
         for (k = 0; k < fill_n; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               queue_word(op_type'($urandom_range(0, 7)), $urandom,
                          7'($urandom_range(0, 127)), 1'b0, '0);
            end else begin
               if (sorted_mode && $urandom_range(0, 4) != 0) op = OP_INS_SORTED;
               else op = op_type'($urandom_range(1, 4));
               queue_word(op, pick_key(!sorted_mode), pick_pos(gen_count + 1), 1'b0, '0);
            end
         end
         query_n = $urandom_range(3, 10);
         for (k = 0; k < query_n; k++) begin
            case ($urandom_range(0, 2))
               0: op = OP_LSEARCH;
               1: op = sorted_mode ? OP_BSEARCH : OP_READ;
               default: op = sorted_mode ? OP_READ : OP_BSEARCH;
            endcase
            queue_word(op, pick_key(1'b1), pick_pos(gen_count), 1'b0, '0);
         end
         first = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_n, what, got, want);
      mismatch_n++;
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   function automatic int send_idle_pct(int phase);
      return (phase == 0) ? 14 : (phase == 1) ? 73 : 0;
   endfunction

   function automatic int recv_idle_pct(int phase);
      return (phase == 0) ? 73 : (phase == 1) ? 14 : 0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            want = apply_word(words[next_word].op, words[next_word].key,
                              words[next_word].pos);
            if (words[next_word].typed) want = words[next_word].exp;
            resp_expected.push_back(want);
            next_word++;
            words_taken <= next_word;
            load_phase <= (next_word < words.size() / 3) ? 0 :
                          (next_word < 2 * words.size() / 3) ? 1 : 2;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_found_location, rsp_key_out, rsp_count, rsp_full_res};
            if (resp_expected.size() == 0) begin
               report_mismatch("result with nothing pending, count", 32'(got.count), 32'd0);
            end else begin
               want = resp_expected.pop_front();
               check_field("status", 32'(got.status), 32'(want.status));
               check_field("found_location", 32'(got.found_location),
                           32'(want.found_location));
               check_field("key_out", got.key_out, want.key_out);
               check_field("count", 32'(got.count), 32'(want.count));
               check_field("full_res", 32'(got.full_res), 32'(want.full_res));
            end
         end
         if (!req_valid || !req_stall) begin
            if (next_word < words.size() &&
                $urandom_range(0, 99) >= send_idle_pct(load_phase)) begin
               req_valid <= 1'b1;
               req_opcode <= words[next_word].op;
               req_key_in <= words[next_word].key;
               req_position <= words[next_word].pos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The long hold-off fills the block so that it has to stall its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (load_phase == 2 && !pressure_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_OFF;
         pressure_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct(load_phase));
      end
   end

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n >= LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (words_taken < words.size() || resp_expected.size() != 0);
      repeat (END_DRAIN) @(posedge clock);
      if (mismatch_n == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
